/* rtl/core/tocp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tocp_pkg;

  localparam int TEMP_W   = 12;
  localparam int CUR_W    = 16;
  localparam int FLASH_W  = 8;
  localparam int TRIP_W   = 4;
  localparam int CLEAR_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CLEAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_TRIP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_CLEAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_PER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_CNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_CNT   = 3'd6;

  // reset values of the configuration registers
  localparam logic signed [TEMP_W-1:0] TEMP_TRIP_RST  = 12'sd600;
  localparam logic signed [TEMP_W-1:0] TEMP_CLEAR_RST = 12'sd500;
  localparam logic [CUR_W-1:0]         CUR_TRIP_RST   = 16'd2700;
  localparam logic [CUR_W-1:0]         CUR_CLEAR_RST  = 16'd500;
  localparam logic [FLASH_W-1:0]       FLASH_PER_RST  = 8'd5;
  localparam logic [TRIP_W-1:0]        TRIP_CNT_RST   = 4'd3;
  localparam logic [CLEAR_W-1:0]       CLEAR_CNT_RST  = 8'd10;

  typedef struct packed {
    logic               lockout;
    logic               warning;
    logic [FLASH_W-1:0] flash_count;
  } tocp_therm_state_t;

  typedef struct packed {
    logic               lockout;
    logic [TRIP_W-1:0]  high_run;
    logic [CLEAR_W-1:0] low_run;
  } tocp_cur_state_t;

  typedef struct packed {
    logic trip;
    logic refresh;
  } tocp_event_t;

endpackage

`default_nettype wire

/* rtl/core/tocp_thermal.sv */
`timescale 1ns / 1ps
`default_nettype none

module tocp_thermal (
  input  wire logic                              sample_ok,
  input  wire logic signed [tocp_pkg::TEMP_W-1:0] temperature,
  input  wire logic signed [tocp_pkg::TEMP_W-1:0] trip_level,
  input  wire logic signed [tocp_pkg::TEMP_W-1:0] clear_level,
  input  wire logic [tocp_pkg::FLASH_W-1:0]      flash_period,
  input  wire tocp_pkg::tocp_therm_state_t       state_cur,
  output tocp_pkg::tocp_therm_state_t            state_nxt,
  output tocp_pkg::tocp_event_t                  evt
);
  import tocp_pkg::*;

  tocp_therm_state_t mid;
  logic              tripped;
  logic              cleared;
  logic [FLASH_W-1:0] cnt_inc;

  always_comb begin
    tripped = sample_ok && !state_cur.lockout && (temperature >= trip_level);
    cleared = sample_ok && state_cur.lockout && (temperature <= clear_level);

    mid = state_cur;
    if (tripped || cleared) begin
      mid.lockout     = tripped;
      mid.warning     = 1'b1;
      mid.flash_count = '0;
    end

    // flash while lockout holds, trip tick counts as first flash tick
    state_nxt = mid;
    cnt_inc   = mid.flash_count + FLASH_W'(1);
    evt.refresh = tripped || cleared;
    if (mid.lockout) begin
      if (cnt_inc >= flash_period) begin
        state_nxt.flash_count = '0;
        state_nxt.warning     = ~mid.warning;
        evt.refresh           = 1'b1;
      end else begin
        state_nxt.flash_count = cnt_inc;
      end
    end
    evt.trip = tripped;
  end

endmodule

`default_nettype wire

/* rtl/core/tocp_current.sv */
`timescale 1ns / 1ps
`default_nettype none

module tocp_current (
  input  wire logic                         sample_valid,
  input  wire logic [tocp_pkg::CUR_W-1:0]   current_ma,
  input  wire logic                         enabled,
  input  wire logic [tocp_pkg::CUR_W-1:0]   trip_level,
  input  wire logic [tocp_pkg::CUR_W-1:0]   clear_level,
  input  wire logic [tocp_pkg::TRIP_W-1:0]  trip_count,
  input  wire logic [tocp_pkg::CLEAR_W-1:0] clear_count,
  input  wire tocp_pkg::tocp_cur_state_t    state_cur,
  output tocp_pkg::tocp_cur_state_t         state_nxt,
  output tocp_pkg::tocp_event_t             evt
);
  import tocp_pkg::*;

  logic [TRIP_W-1:0]  high_sat;
  logic [CLEAR_W-1:0] low_sat;

  always_comb begin
    // saturating run counters
    high_sat = (state_cur.high_run < trip_count) ?
               state_cur.high_run + TRIP_W'(1) : state_cur.high_run;
    low_sat  = (state_cur.low_run < clear_count) ?
               state_cur.low_run + CLEAR_W'(1) : state_cur.low_run;

    state_nxt   = state_cur;
    evt.trip    = 1'b0;
    evt.refresh = 1'b0;

    if (!sample_valid) begin
      state_nxt.high_run = '0;
      if (state_cur.lockout) begin
        state_nxt.low_run = '0;
      end
    end else if (!state_cur.lockout) begin
      state_nxt.low_run = '0;
      if (enabled && (current_ma >= trip_level)) begin
        state_nxt.high_run = high_sat;
        if (high_sat >= trip_count) begin
          state_nxt.lockout = 1'b1;
          evt.trip          = 1'b1;
          evt.refresh       = 1'b1;
        end
      end else begin
        state_nxt.high_run = '0;
      end
    end else begin
      state_nxt.high_run = '0;
      if (current_ma <= clear_level) begin
        state_nxt.low_run = low_sat;
        if (low_sat >= clear_count) begin
          state_nxt.lockout = 1'b0;
          state_nxt.low_run = '0;
          evt.refresh       = 1'b1;
        end
      end else begin
        state_nxt.low_run = '0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/thermal_overcurrent_protection_top.sv */
// path: an accepted item is registered in the input register, then moves into the
//   result register once that is free, where the result can be taken
// throughput: one item per cycle while out_stall is low; input register, one pass of
//   compares and counter updates against the protection state, then the result register
// a result waiting under out_stall still lets one more item into the input register
// reset (rst_n low, synchronous): lockouts off, warning visible, counters cleared,
//   thresholds back to defaults, both pipeline registers empty
`timescale 1ns / 1ps
`default_nettype none

module thermal_overcurrent_protection_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [tocp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tocp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // tick item in
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic                              in_sensor_present,
  input  wire logic                              in_temp_valid,
  input  wire logic signed [tocp_pkg::TEMP_W-1:0] in_temperature,
  input  wire logic                              in_current_valid,
  input  wire logic [tocp_pkg::CUR_W-1:0]        in_current_ma,
  input  wire logic                              in_converter_enabled,
  // result item out
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic                              out_thermal_lockout,
  output      logic                              out_current_lockout,
  output      logic                              out_warning_visible,
  output      logic                              out_output_permitted,
  output      logic                              out_disable_pulse,
  output      logic                              out_refresh_event
);
  import tocp_pkg::*;

  // configuration registers
  logic signed [TEMP_W-1:0] temp_trip_r;
  logic signed [TEMP_W-1:0] temp_clear_r;
  logic [CUR_W-1:0]         cur_trip_r;
  logic [CUR_W-1:0]         cur_clear_r;
  logic [FLASH_W-1:0]       flash_per_r;
  logic [TRIP_W-1:0]        trip_cnt_r;
  logic [CLEAR_W-1:0]       clear_cnt_r;

  // input register
  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  logic                     s1_present_r;
  logic                     s1_tvalid_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  logic                     s1_cvalid_r;
  logic [CUR_W-1:0]         s1_cur_r;
  logic                     s1_enabled_r;

  // protection state
  tocp_therm_state_t therm_r;
  tocp_therm_state_t therm_nxt;
  tocp_cur_state_t   cur_r;
  tocp_cur_state_t   cur_nxt;
  tocp_event_t       therm_evt;
  tocp_event_t       cur_evt;

  // result register
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_thermal_r;
  logic out_current_r;
  logic out_warning_r;
  logic out_disable_r;
  logic out_refresh_r;

  logic s2_ready;
  logic s2_load;
  logic in_fire;

  // result register frees up when empty or being taken this cycle
  assign s2_ready = !out_valid_r || !out_stall;
  assign s2_load  = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // config writes; the user must write only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trip_r  <= TEMP_TRIP_RST;
      temp_clear_r <= TEMP_CLEAR_RST;
      cur_trip_r   <= CUR_TRIP_RST;
      cur_clear_r  <= CUR_CLEAR_RST;
      flash_per_r  <= FLASH_PER_RST;
      trip_cnt_r   <= TRIP_CNT_RST;
      clear_cnt_r  <= CLEAR_CNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TEMP_TRIP:  temp_trip_r  <= $signed(cfg_wdata[TEMP_W-1:0]);
        REG_TEMP_CLEAR: temp_clear_r <= $signed(cfg_wdata[TEMP_W-1:0]);
        REG_CUR_TRIP:   cur_trip_r   <= cfg_wdata[CUR_W-1:0];
        REG_CUR_CLEAR:  cur_clear_r  <= cfg_wdata[CUR_W-1:0];
        REG_FLASH_PER:  flash_per_r  <= cfg_wdata[FLASH_W-1:0];
        REG_TRIP_CNT:   trip_cnt_r   <= cfg_wdata[TRIP_W-1:0];
        REG_CLEAR_CNT:  clear_cnt_r  <= cfg_wdata[CLEAR_W-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // temperature lockout, hysteresis and warning flash
  tocp_thermal u_thermal (
    .sample_ok    (s1_present_r && s1_tvalid_r),
    .temperature  (s1_temp_r),
    .trip_level   (temp_trip_r),
    .clear_level  (temp_clear_r),
    .flash_period (flash_per_r),
    .state_cur    (therm_r),
    .state_nxt    (therm_nxt),
    .evt          (therm_evt)
  );

  // overcurrent run counting
  tocp_current u_current (
    .sample_valid (s1_cvalid_r),
    .current_ma   (s1_cur_r),
    .enabled      (s1_enabled_r),
    .trip_level   (cur_trip_r),
    .clear_level  (cur_clear_r),
    .trip_count   (trip_cnt_r),
    .clear_count  (clear_cnt_r),
    .state_cur    (cur_r),
    .state_nxt    (cur_nxt),
    .evt          (cur_evt)
  );

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      therm_r.lockout     <= 1'b0;
      therm_r.warning     <= 1'b1;
      therm_r.flash_count <= '0;
      cur_r.lockout       <= 1'b0;
      cur_r.high_run      <= '0;
      cur_r.low_run       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // state advances once per item, as it moves into the result register
      if (s2_load) begin
        therm_r <= therm_nxt;
        cur_r   <= cur_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_present_r <= in_sensor_present;
      s1_tvalid_r  <= in_temp_valid;
      s1_temp_r    <= in_temperature;
      s1_cvalid_r  <= in_current_valid;
      s1_cur_r     <= in_current_ma;
      s1_enabled_r <= in_converter_enabled;
    end
    if (s2_load) begin
      out_thermal_r <= therm_nxt.lockout;
      out_current_r <= cur_nxt.lockout;
      out_warning_r <= therm_nxt.warning;
      out_disable_r <= therm_evt.trip || cur_evt.trip;
      out_refresh_r <= therm_evt.refresh || cur_evt.refresh;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_thermal_lockout  = out_thermal_r;
  assign out_current_lockout  = out_current_r;
  assign out_warning_visible  = out_warning_r;
  assign out_output_permitted = !out_thermal_r && !out_current_r;
  assign out_disable_pulse    = out_disable_r;
  assign out_refresh_event    = out_refresh_r;

  // a shutdown pulse always comes with a lockout that is now set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_disable_r |-> out_thermal_r || out_current_r)
    else $error("disable pulse without active lockout");

  // without thermal lockout the flash counter rests at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    !therm_r.lockout |-> therm_r.flash_count == '0)
    else $error("flash counter running outside thermal lockout");

  // the warning is steady on while no thermal lockout holds
  assert property (@(posedge clk) disable iff (!rst_n)
    !therm_r.lockout |-> therm_r.warning)
    else $error("warning hidden outside thermal lockout");

  // the recovery count only runs while the overcurrent lockout holds
  assert property (@(posedge clk) disable iff (!rst_n)
    !cur_r.lockout |-> cur_r.low_run == '0)
    else $error("recovery count running without overcurrent lockout");

  // the input side only stalls with an item held in the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
